>>> hdl/fas_pkg.sv
// Package: shared widths and field types for the single-precision adder.
package fas_pkg;
    localparam int unsigned ExpW  = 8;
    localparam int unsigned FracW = 23;
    localparam int unsigned SigW  = 24;
    localparam int unsigned SumW  = 26;
    localparam logic [ExpW-1:0] ExpMax = 8'hFF;

    typedef struct packed {
        logic            sign;
        logic [SigW:0]   mag;
        logic [ExpW-1:0] exp;
    } fas_norm_t;
endpackage

>>> hdl/fas_lod.sv
// Leading-one detector: left shift count that brings the leading one to bit 23.
module fas_lod (
    input  logic [fas_pkg::SigW-1:0] mag,
    output logic [4:0]               shift
);
    always_comb begin
        shift = 5'(fas_pkg::FracW);
        for (int i = 0; i < fas_pkg::SigW; i++) begin
            if (mag[i]) begin
                shift = 5'(fas_pkg::FracW - i);
            end
        end
    end
endmodule

>>> hdl/float32_add_sub_truncating.sv
// Top level: pipelined single-precision add/subtract, truncating.
//
// Four register stages (align, add, magnitude/leading-one, normalise), one
// transfer accepted per cycle while the output stage is not stalled. Operands
// are always taken as normal numbers with a hidden one. Zeros, subnormals,
// infinities and NaNs are not decoded. Results are truncated. A zero
// significand sum raises zero_result with an all-zero word. An exponent above
// 255 or below 0 raises range_error and saturates the exponent to 255 or 0
// with a zero fraction. The pipeline advances whenever the output stage is
// empty or being taken, so a stall holds all stages.
module float32_add_sub_truncating (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // a_bits[31:0], b_bits[63:32]
    input  logic        s_tuser,  // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // sum_bits[31:0]
    output logic [1:0]  m_tuser   // zero_result[0], range_error[1]
);
    localparam int unsigned SW = fas_pkg::SumW;

    logic [3:0] vld_reg, vld_next;
    logic       adv;

    // stage 1 regs
    logic            s1_sa_reg, s1_sb_reg, s1_sub_reg;
    logic [23:0]     s1_ma_reg, s1_mb_reg;
    logic [7:0]      s1_ep_reg;
    // stage 2
    logic [SW-1:0]   s2_r_reg;
    logic [7:0]      s2_ep_reg;
    // stage 3
    logic            s3_sign_reg;
    logic [24:0]     s3_mag_reg;
    logic [7:0]      s3_ep_reg;
    logic [4:0]      s3_sh_reg;
    // stage 4
    logic [31:0]     s4_sum_reg;
    logic            s4_zero_reg, s4_err_reg;

    assign adv      = !vld_reg[3] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[3];
    assign m_tdata  = s4_sum_reg;
    assign m_tuser  = {s4_err_reg, s4_zero_reg};

    always_comb begin
        vld_next = adv ? {vld_reg[2:0], s_tvalid} : vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: unpack, compare exponents, align the smaller significand
    logic [31:0] a_w, b_w;
    logic [7:0]  ea, eb, dab, dba;
    logic [23:0] ma, mb;
    assign a_w = s_tdata[31:0];
    assign b_w = s_tdata[63:32];
    assign ea  = a_w[30:23];
    assign eb  = b_w[30:23];
    assign ma  = {1'b1, a_w[22:0]};
    assign mb  = {1'b1, b_w[22:0]};
    assign dab = ea - eb;
    assign dba = eb - ea;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_sa_reg  <= a_w[31];
            s1_sb_reg  <= b_w[31];
            s1_sub_reg <= s_tuser;
            if (ea >= eb) begin
                s1_ep_reg <= ea;
                s1_ma_reg <= ma;
                s1_mb_reg <= (dab < 8'd24) ? (mb >> dab) : '0;
            end else begin
                s1_ep_reg <= eb;
                s1_ma_reg <= (dba < 8'd24) ? (ma >> dba) : '0;
                s1_mb_reg <= mb;
            end
        end
    end

    // stage 2: two's complement and add or subtract
    logic [SW-1:0] ta, tb;
    assign ta = s1_sa_reg ? -SW'(s1_ma_reg) : SW'(s1_ma_reg);
    assign tb = s1_sb_reg ? -SW'(s1_mb_reg) : SW'(s1_mb_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_r_reg  <= s1_sub_reg ? (ta - tb) : (ta + tb);
            s2_ep_reg <= s1_ep_reg;
        end
    end

    // stage 3: sign and magnitude, leading-one count
    logic [SW-1:0] mag_w;
    logic [4:0]    sh_w;
    assign mag_w = s2_r_reg[SW-1] ? -s2_r_reg : s2_r_reg;

    fas_lod u_lod (.mag(mag_w[23:0]), .shift(sh_w));

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_sign_reg <= s2_r_reg[SW-1];
            s3_mag_reg  <= mag_w[24:0];
            s3_ep_reg   <= s2_ep_reg;
            s3_sh_reg   <= sh_w;
        end
    end

    // stage 4: normalise, range check, pack
    logic [9:0]  e_w;
    logic [22:0] frac_w;
    logic [23:0] shl_w;
    assign shl_w = s3_mag_reg[23:0] << s3_sh_reg;

    always_comb begin
        if (s3_mag_reg[24]) begin
            e_w    = {2'b0, s3_ep_reg} + 10'd1;
            frac_w = s3_mag_reg[23:1];
        end else begin
            e_w    = {2'b0, s3_ep_reg} - {5'b0, s3_sh_reg};
            frac_w = shl_w[22:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_zero_reg <= 1'b0;
            s4_err_reg  <= 1'b0;
            if (s3_mag_reg == '0) begin
                s4_zero_reg <= 1'b1;
                s4_sum_reg  <= '0;
            end else if (e_w[9]) begin
                s4_err_reg <= 1'b1;
                s4_sum_reg <= {s3_sign_reg, 31'b0};
            end else if (e_w[8]) begin
                s4_err_reg <= 1'b1;
                s4_sum_reg <= {s3_sign_reg, fas_pkg::ExpMax, 23'b0};
            end else begin
                s4_sum_reg <= {s3_sign_reg, e_w[7:0], frac_w};
            end
        end
    end
endmodule

>>> tb/float32_add_sub_truncating_chk.sv
// Checker: watches both channels, predicts each adder result and compares it.
module float32_add_sub_truncating_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          n_errors,
    output int          n_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        range_error;
        logic        zero_result;
        logic [31:0] sum_bits;
    } fas_result_t;

    fas_result_t sum_queue[$];

    function automatic fas_result_t add_truncated(logic [31:0] a, logic [31:0] b, logic sub);
        logic [31:0] ma, mb, ta, tb, r, mag;
        logic [7:0]  ea, eb, ep;
        logic        sg;
        int          e, sh;
        logic [22:0] frac;
        fas_result_t res;
        ea = a[30:23];
        eb = b[30:23];
        ma = {9'd1, a[22:0]};
        mb = {9'd1, b[22:0]};
        if (ea >= eb) begin
            ep = ea;
            mb = mb >> (ea - eb);
        end else begin
            ep = eb;
            ma = ma >> (eb - ea);
        end
        ta = a[31] ? -ma : ma;
        tb = b[31] ? -mb : mb;
        r = sub ? ta - tb : ta + tb;
        sg = r[31];
        mag = sg ? -r : r;
        res = '0;
        if (mag == 0) begin
            res.zero_result = 1'b1;
        end else begin
            if (mag[24]) begin
                frac = mag[23:1];
                e = ep + 1;
            end else begin
                sh = 0;
                while (sh < 23 && !mag[23-sh]) sh++;
                frac = 23'(mag << sh);
                e = int'(ep) - sh;
            end
            if (e > 255) begin
                res.range_error = 1'b1;
                res.sum_bits = {sg, 8'hFF, 23'd0};
            end else if (e < 0) begin
                res.range_error = 1'b1;
                res.sum_bits = {sg, 31'd0};
            end else begin
                res.sum_bits = {sg, 8'(e), frac};
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        fas_result_t got, want;
        if (!aresetn) begin
            n_errors = 0;
        end else begin
            if (s_tvalid && s_tready)
                sum_queue.push_back(add_truncated(s_tdata[31:0], s_tdata[63:32], s_tuser));
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata};
                if (sum_queue.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected result %h", got);
                end else begin
                    want = sum_queue.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch: expected sum %h zero %b range %b, got %h %b %b",
                                     want.sum_bits, want.zero_result, want.range_error,
                                     got.sum_bits, got.zero_result, got.range_error);
                    end
                end
            end
        end
        n_pending = sum_queue.size();
    end
endmodule

>>> tb/float32_add_sub_truncating_tb.sv
// Testbench top: drives stimulus into the truncating float adder and gives the verdict.
module float32_add_sub_truncating_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    int          n_errors, n_pending;
    int          send_idle_pct = 20;   // chance per cycle that the sender holds off
    int          recv_idle_pct = 64;   // chance per cycle that the receiver holds off
    bit          recv_hold = 1'b0;     // long back-pressure stretch in progress

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    float32_add_sub_truncating i_dut (.*);

    float32_add_sub_truncating_chk i_chk (.*);

    // Receiver: random readiness, forced low during a long hold.
    always @(posedge aclk) begin
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long hold-off, counted in its own process.
    initial begin
        wait (aresetn);
        repeat (300) @(posedge aclk);
        recv_hold = 1'b1;
        repeat (200) @(posedge aclk);
        recv_hold = 1'b0;
    end

    // Random operand: often close exponents so that cancellation and carry paths get hit, sometimes extreme ones.
    function automatic logic [31:0] rand_operand(logic [7:0] near);
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(5))
            0, 1: w[30:23] = near + 8'($urandom_range(4)) - 8'd2;
            2:    w[30:23] = $urandom_range(1) ? 8'hFF - 8'($urandom_range(3)) : 8'($urandom_range(3));
            default: ;
        endcase
        return w;
    endfunction

    // Offer one transfer, with random idle cycles, and hold until accepted.
    task automatic send_pair(logic [31:0] a, logic [31:0] b, logic sub);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= sub;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] a;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zeros, equal cancellation, carry, overflow, underflow, shift past 24.
        send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_pair(32'h3F80_0000, 32'h3F80_0000, 1'b1);
        send_pair(32'h3F80_0000, 32'hBF80_0000, 1'b0);
        send_pair(32'h3F80_0000, 32'h3F80_0000, 1'b0);
        send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0);
        send_pair(32'h7F80_0000, 32'h7F80_0000, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_pair(32'h0080_0001, 32'h0080_0000, 1'b1);
        send_pair(32'h0000_0001, 32'h0000_0000, 1'b1);
        send_pair(32'h4B80_0000, 32'h3F80_0000, 1'b0);
        send_pair(32'h4C00_0000, 32'h3F80_0000, 1'b1);
        send_pair(32'h7F80_0000, 32'h0000_0000, 1'b0);
        send_pair(32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
        send_pair(32'h8000_0000, 32'h0000_0000, 1'b1);
        send_pair(32'h3FFF_FFFF, 32'h3F80_0000, 1'b0);
        send_pair(32'hC000_0000, 32'h4000_0001, 1'b0);
        send_pair(32'h7F00_0000, 32'h7F00_0000, 1'b0);
        send_pair(32'hFF7F_FFFF, 32'h7F7F_FFFF, 1'b1);
        drain();   // pause until every expected result has come

        for (int i = 0; i < 1350; i++) begin
            if (i == 450) begin
                send_idle_pct = 64;
                recv_idle_pct = 20;
            end
            if (i == 900) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            a = rand_operand(8'($urandom));
            send_pair(a, rand_operand(a[30:23]), 1'($urandom));
        end
        drain();
        repeat (10) @(posedge aclk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
